FILE: rtl/core/iet_pkg.sv
package iet_pkg;

    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [1:0] CMD_BUTTON = 2'd0;
    localparam logic [1:0] CMD_KEY    = 2'd1;
    localparam logic [1:0] CMD_FRAME  = 2'd2;
    localparam logic [1:0] CMD_QUERY  = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_CAPTURE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DC_FRAMES = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DC_RADIUS = 2'd2;

    localparam logic [7:0]  DC_FRAMES_RST   = 8'd30;
    localparam logic [15:0] DC_RADIUS_RST   = 16'd36;
    localparam logic [31:0] PRESS_FRAME_RST = 32'hFFFF_FC18;

    typedef struct packed {
        logic key_evt;
        logic frame;
        logic down;
    } t_key_upd;

    typedef struct packed {
        logic pressed;
        logic held;
    } t_key_stat;

    typedef struct packed {
        logic        level;
        logic        press_seen;
        logic [31:0] press_frame;
    } t_key_entry;

    typedef struct packed {
        logic btn_evt;
        logic frame;
        logic down;
    } t_btn_upd;

    typedef struct packed {
        logic down;
        logic clicked;
        logic released;
        logic dbl;
    } t_btn_stat;

endpackage

FILE: rtl/core/iet_ram.sv
module iet_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/iet_key_store.sv
module iet_key_store #(
    parameter int KEY_COUNT = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rd_en,
    input  logic [7:0]          i_rd_key,
    input  logic [7:0]          i_key,
    input  iet_pkg::t_key_upd   i_upd,
    input  logic                i_commit,
    output iet_pkg::t_key_stat  o_stat
);
    import iet_pkg::*;

    localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    logic [KW+7:0]        rd_wide;
    logic [KW+7:0]        cur_wide;
    logic [KW-1:0]        rd_idx;
    logic [KW-1:0]        cur_idx;
    logic                 key_ok;
    logic                 wr;
    logic                 press;
    t_key_entry           ram_q;
    t_key_entry           entry_cur;
    t_key_entry           entry_new;
    logic [KEY_COUNT-1:0] r_valid;
    logic [31:0]          r_frame_cnt;
    logic                 r_fwd_vld;
    logic [KW-1:0]        r_fwd_idx;
    t_key_entry           r_fwd_data;

    assign rd_wide  = {{KW{1'b0}}, i_rd_key};
    assign cur_wide = {{KW{1'b0}}, i_key};
    assign rd_idx   = rd_wide[KW-1:0];
    assign cur_idx  = cur_wide[KW-1:0];
    assign key_ok   = ({24'd0, i_key} < 32'(KEY_COUNT));
    assign wr       = i_upd.key_evt & key_ok;
    assign press    = wr & i_upd.down;

    iet_ram #(
        .WIDTH ($bits(t_key_entry)),
        .DEPTH (KEY_COUNT)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_commit & wr),
        .i_waddr (cur_idx),
        .i_wdata (entry_new),
        .i_re    (i_rd_en),
        .i_raddr (rd_idx),
        .o_rdata (ram_q)
    );

    // latest write covers a read issued on the same edge
    always_comb begin
        if (r_fwd_vld && (r_fwd_idx == cur_idx)) begin
            entry_cur = r_fwd_data;
        end else if (r_valid[cur_idx]) begin
            entry_cur = ram_q;
        end else begin
            entry_cur = '0;
        end
    end

    // a press tagged with the current frame number counts as this frame's edge
    always_comb begin
        entry_new.level       = i_upd.down;
        entry_new.press_seen  = entry_cur.press_seen | i_upd.down;
        entry_new.press_frame = i_upd.down ? r_frame_cnt : entry_cur.press_frame;
    end

    always_comb begin
        o_stat.held    = key_ok & (wr ? i_upd.down : entry_cur.level);
        o_stat.pressed = key_ok & ~i_upd.frame &
                         (press | (entry_cur.press_seen &
                                   (entry_cur.press_frame == r_frame_cnt)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_frame_cnt <= '0;
            r_fwd_vld   <= 1'b0;
            r_fwd_idx   <= '0;
            r_fwd_data  <= '0;
        end else if (i_commit) begin
            if (i_upd.frame) begin
                r_frame_cnt <= r_frame_cnt + 32'd1;
            end
            if (wr) begin
                r_valid[cur_idx] <= 1'b1;
                r_fwd_vld        <= 1'b1;
                r_fwd_idx        <= cur_idx;
                r_fwd_data       <= entry_new;
            end
        end
    end

endmodule

FILE: rtl/core/iet_buttons.sv
module iet_buttons #(
    parameter int BUTTON_COUNT = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_button,
    input  logic signed [15:0] i_px,
    input  logic signed [15:0] i_py,
    input  iet_pkg::t_btn_upd  i_upd,
    input  logic               i_commit,
    input  logic               i_capture,
    input  logic [7:0]         i_dc_frames,
    input  logic [15:0]        i_dc_radius,
    output iet_pkg::t_btn_stat o_stat
);
    import iet_pkg::*;

    logic [BUTTON_COUNT-1:0] r_now;
    logic [BUTTON_COUNT-1:0] r_prev;
    logic [31:0]             r_frame_cnt;
    logic [31:0]             r_press_frame;
    logic [15:0]             r_press_x;
    logic [15:0]             r_press_y;
    logic                    r_dbl;

    logic [BUTTON_COUNT-1:0] n_now;
    logic [BUTTON_COUNT-1:0] n_prev;
    logic                    n_dbl;
    logic [BUTTON_COUNT-1:0] mask;
    logic [BUTTON_COUNT-1:0] now_sh;
    logic [BUTTON_COUNT-1:0] prev_sh;
    logic                    btn_ok;
    logic                    left_press;
    logic signed [16:0]      dx;
    logic signed [16:0]      dy;
    logic [16:0]             adx;
    logic [16:0]             ady;
    logic                    far;
    logic [15:0]             sq_x;
    logic [15:0]             sq_y;
    logic [16:0]             dist_sq;
    logic [31:0]             gap;
    logic                    hit;
    logic                    now_bit;
    logic                    prev_bit;

    assign btn_ok     = ({6'd0, i_button} < 8'(BUTTON_COUNT));
    assign mask       = BUTTON_COUNT'(1) << i_button;
    assign left_press = i_upd.btn_evt & i_upd.down & (i_button == 2'd0);

    // any axis at 256 or more already exceeds the largest radius
    always_comb begin
        dx      = {i_px[15], i_px} - {r_press_x[15], r_press_x};
        dy      = {i_py[15], i_py} - {r_press_y[15], r_press_y};
        adx     = dx[16] ? 17'(-dx) : 17'(dx);
        ady     = dy[16] ? 17'(-dy) : 17'(dy);
        far     = (|adx[16:8]) | (|ady[16:8]);
        sq_x    = {8'd0, adx[7:0]} * {8'd0, adx[7:0]};
        sq_y    = {8'd0, ady[7:0]} * {8'd0, ady[7:0]};
        dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
        gap     = r_frame_cnt - r_press_frame;
        hit     = (gap <= {24'd0, i_dc_frames}) && !far && (dist_sq < {1'b0, i_dc_radius});
    end

    always_comb begin
        n_now = r_now;
        if (i_upd.btn_evt && btn_ok) begin
            n_now = i_upd.down ? (r_now | mask) : (r_now & ~mask);
        end
        n_prev = i_upd.frame ? r_now : r_prev;
        if (i_upd.frame) begin
            n_dbl = 1'b0;
        end else if (left_press) begin
            n_dbl = hit;
        end else begin
            n_dbl = r_dbl;
        end
    end

    assign now_sh   = n_now >> i_button;
    assign prev_sh  = n_prev >> i_button;
    assign now_bit  = btn_ok & ~i_capture & now_sh[0];
    assign prev_bit = btn_ok & ~i_capture & prev_sh[0];

    always_comb begin
        o_stat.down     = now_bit;
        o_stat.clicked  = now_bit & ~prev_bit;
        o_stat.released = prev_bit & ~now_bit;
        o_stat.dbl      = n_dbl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now         <= '0;
            r_prev        <= '0;
            r_frame_cnt   <= '0;
            r_press_frame <= PRESS_FRAME_RST;
            r_press_x     <= '0;
            r_press_y     <= '0;
            r_dbl         <= 1'b0;
        end else if (i_commit) begin
            r_now  <= n_now;
            r_prev <= n_prev;
            r_dbl  <= n_dbl;
            if (i_upd.frame) begin
                r_frame_cnt <= r_frame_cnt + 32'd1;
            end
            if (left_press) begin
                r_press_frame <= r_frame_cnt;
                r_press_x     <= i_px;
                r_press_y     <= i_py;
            end
        end
    end

endmodule

FILE: rtl/core/input_event_tracker.sv
// input event tracker: keeps mouse button and key state for a user interface
// the slave stream takes one request per cycle unless stalled: tuser carries
// the command (button event, key event, new frame, status query), tdata the
// button, the pressed flag, the key code and the pointer position
// every request gives exactly one status result on the master stream, taken
// after the request's own update: button down, clicked, released, key
// pressed, key held and the double-click flag
// a request is held in the update stage register, its result then in the
// result register; throughput is one request per cycle unless the receiver
// stalls, set by the single update stage, key memory read on acceptance
// capture masks the three button results; config writes on the plain write
// port must only be made while the stream is idle; the block does not enforce it
// reset (synchronous, active low) clears all button, key and frame state and
// loads the default config; no clearing pass is needed after reset
// when the receiver stalls, the result register holds and the update stage
// keeps one more request before tready drops
module input_event_tracker #(
    parameter int KEY_COUNT    = 256,
    parameter int BUTTON_COUNT = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // button[1:0], pressed[2], key_code[10:3], pointer_x[26:11], pointer_y[42:27]
    input  logic [iet_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // command[1:0]
    input  logic [iet_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // button_down[0], button_clicked[1], button_released[2], key_pressed[3],
    // key_held[4], double_click[5]
    output logic [iet_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [iet_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [iet_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import iet_pkg::*;

    logic               r_capture;
    logic [7:0]         r_dc_frames;
    logic [15:0]        r_dc_radius;

    logic               r_s1_valid;
    logic [1:0]         r_cmd;
    logic [1:0]         r_button;
    logic               r_pressed;
    logic [7:0]         r_key;
    logic signed [15:0] r_px;
    logic signed [15:0] r_py;

    logic               r_out_valid;
    logic [5:0]         r_out_data;

    logic               accept;
    logic               s1_adv;
    t_key_upd           key_upd;
    t_key_stat          key_stat;
    t_btn_upd           btn_upd;
    t_btn_stat          btn_stat;

    assign s1_adv        = r_s1_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_s1_valid | s1_adv;
    assign accept        = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capture   <= 1'b0;
            r_dc_frames <= DC_FRAMES_RST;
            r_dc_radius <= DC_RADIUS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CAPTURE: begin
                    r_capture <= i_cfg_data[0];
                end
                CFG_DC_FRAMES: begin
                    r_dc_frames <= i_cfg_data[7:0];
                end
                CFG_DC_RADIUS: begin
                    r_dc_radius <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= s_axis_tuser[1:0];
            r_button  <= s_axis_tdata[1:0];
            r_pressed <= s_axis_tdata[2];
            r_key     <= s_axis_tdata[10:3];
            r_px      <= s_axis_tdata[26:11];
            r_py      <= s_axis_tdata[42:27];
        end
    end

    always_comb begin
        key_upd.key_evt = (r_cmd == CMD_KEY);
        key_upd.frame   = (r_cmd == CMD_FRAME);
        key_upd.down    = r_pressed;
        btn_upd.btn_evt = (r_cmd == CMD_BUTTON);
        btn_upd.frame   = (r_cmd == CMD_FRAME);
        btn_upd.down    = r_pressed;
    end

    iet_key_store #(
        .KEY_COUNT (KEY_COUNT)
    ) u_key_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (accept),
        .i_rd_key (s_axis_tdata[10:3]),
        .i_key    (r_key),
        .i_upd    (key_upd),
        .i_commit (s1_adv),
        .o_stat   (key_stat)
    );

    iet_buttons #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_buttons (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_button    (r_button),
        .i_px        (r_px),
        .i_py        (r_py),
        .i_upd       (btn_upd),
        .i_commit    (s1_adv),
        .i_capture   (r_capture),
        .i_dc_frames (r_dc_frames),
        .i_dc_radius (r_dc_radius),
        .o_stat      (btn_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= {btn_stat.dbl, key_stat.held, key_stat.pressed,
                           btn_stat.released, btn_stat.clicked, btn_stat.down};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_data};

endmodule
